// ===== src/pmfn_pkg.sv =====
`default_nettype none

package pmfn_pkg;

  localparam int TAPS_DEFAULT       = 101;
  localparam int PHASE_BITS_DEFAULT = 15;
  localparam int ROM_LEN            = 101;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN          = 2'd1;

  localparam logic [CFG_W-1:0] FREE_RUN_RESET  = 15'd341;
  localparam logic [CFG_W-1:0] LOOP_GAIN_RESET = 15'd137;

  // sine polynomial constants, quarter-wave in Q15
  localparam logic [16:0] SIN_K1      = 17'd51472;
  localparam logic [16:0] SIN_K2      = 17'd21167;
  localparam logic [15:0] SIN_K3      = 16'd2611;
  localparam logic [13:0] SIN_QUARTER = 14'd8192;

  localparam logic signed [15:0] COEF_ROM [ROM_LEN] = '{
    16'sd46,  16'sd46,  16'sd48,  16'sd51,  16'sd54,  16'sd59,  16'sd65,  16'sd72,
    16'sd80,  16'sd89,  16'sd98,  16'sd109, 16'sd120, 16'sd133, 16'sd146, 16'sd160,
    16'sd174, 16'sd189, 16'sd205, 16'sd221, 16'sd238, 16'sd255, 16'sd272, 16'sd290,
    16'sd307, 16'sd325, 16'sd343, 16'sd361, 16'sd379, 16'sd396, 16'sd413, 16'sd430,
    16'sd447, 16'sd463, 16'sd479, 16'sd494, 16'sd508, 16'sd521, 16'sd534, 16'sd546,
    16'sd557, 16'sd568, 16'sd577, 16'sd585, 16'sd593, 16'sd599, 16'sd604, 16'sd608,
    16'sd611, 16'sd612, 16'sd613, 16'sd612, 16'sd611, 16'sd608, 16'sd604, 16'sd599,
    16'sd593, 16'sd585, 16'sd577, 16'sd568, 16'sd557, 16'sd546, 16'sd534, 16'sd521,
    16'sd508, 16'sd494, 16'sd479, 16'sd463, 16'sd447, 16'sd430, 16'sd413, 16'sd396,
    16'sd379, 16'sd361, 16'sd343, 16'sd325, 16'sd307, 16'sd290, 16'sd272, 16'sd255,
    16'sd238, 16'sd221, 16'sd205, 16'sd189, 16'sd174, 16'sd160, 16'sd146, 16'sd133,
    16'sd120, 16'sd109, 16'sd98,  16'sd89,  16'sd80,  16'sd72,  16'sd65,  16'sd59,
    16'sd54,  16'sd51,  16'sd48,  16'sd46,  16'sd46
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DET_MUL,
    ST_DET_WR,
    ST_TAP_ISSUE,
    ST_TAP_DRAIN,
    ST_GAIN_MUL,
    ST_PHASE_UPD,
    ST_SIN_PREP,
    ST_SIN_UU,
    ST_SIN_U2C,
    ST_SIN_R1,
    ST_SIN_R2,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [2:0] {
    MUL_DET,
    MUL_TAP,
    MUL_GAIN,
    MUL_UU,
    MUL_U2C,
    MUL_R1,
    MUL_R2
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     det_write;
    logic     tap_issue;
    logic     hist_step;
    logic     phase_upd;
    logic     sin_prep;
    logic     u2_latch;
    logic     finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pipe_busy;
    logic out_busy;
  } ctl_stat_t;

  // coefficients past the table read as zero
  function automatic logic signed [15:0] coef_at(input logic [7:0] idx);
    if (idx < 8'(ROM_LEN)) begin
      return COEF_ROM[idx[6:0]];
    end else begin
      return 16'sd0;
    end
  endfunction

  // Q15 product: floor by 2^15, then saturate to 16 bits
  function automatic logic signed [15:0] qsat(input logic signed [35:0] p);
    logic signed [20:0] q;
    q = p[35:15];
    if (q > 21'sd32767) begin
      return 16'sh7fff;
    end else if (q < -21'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s > 17'sd32767) begin
      return 16'sh7fff;
    end else if (s < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return s[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/pmfn_if.sv =====
`default_nettype none

interface pmfn_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface pmfn_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vco_sample;
  logic signed [15:0] error_sample;

  modport source (output valid, output vco_sample, output error_sample, input ready);
  modport sink   (input valid, input vco_sample, input error_sample, output ready);
endinterface

`default_nettype wire

// ===== src/pmfn_ctrl.sv =====
`default_nettype none

module pmfn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pmfn_pkg::ctl_stat_t stat,
  output pmfn_pkg::ctl_cmd_t  cmd
);

  pmfn_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmfn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = pmfn_pkg::MUL_DET;
    unique case (state)
      pmfn_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pmfn_pkg::ST_DET_MUL;
        end
      end
      pmfn_pkg::ST_DET_MUL: begin
        cmd.mul_sel = pmfn_pkg::MUL_DET;
        cmd.mul_en  = 1'b1;
        state_next  = pmfn_pkg::ST_DET_WR;
      end
      pmfn_pkg::ST_DET_WR: begin
        cmd.det_write = 1'b1;
        state_next    = pmfn_pkg::ST_TAP_ISSUE;
      end
      pmfn_pkg::ST_TAP_ISSUE: begin
        cmd.mul_sel   = pmfn_pkg::MUL_TAP;
        cmd.tap_issue = 1'b1;
        if (stat.last_issue) begin
          state_next = pmfn_pkg::ST_TAP_DRAIN;
        end
      end
      pmfn_pkg::ST_TAP_DRAIN: begin
        // let the read and multiply stages empty into the sum
        cmd.mul_sel = pmfn_pkg::MUL_TAP;
        if (!stat.pipe_busy) begin
          state_next = pmfn_pkg::ST_GAIN_MUL;
        end
      end
      pmfn_pkg::ST_GAIN_MUL: begin
        cmd.mul_sel   = pmfn_pkg::MUL_GAIN;
        cmd.mul_en    = 1'b1;
        cmd.hist_step = 1'b1;
        state_next    = pmfn_pkg::ST_PHASE_UPD;
      end
      pmfn_pkg::ST_PHASE_UPD: begin
        cmd.phase_upd = 1'b1;
        state_next    = pmfn_pkg::ST_SIN_PREP;
      end
      pmfn_pkg::ST_SIN_PREP: begin
        cmd.sin_prep = 1'b1;
        state_next   = pmfn_pkg::ST_SIN_UU;
      end
      pmfn_pkg::ST_SIN_UU: begin
        cmd.mul_sel = pmfn_pkg::MUL_UU;
        cmd.mul_en  = 1'b1;
        state_next  = pmfn_pkg::ST_SIN_U2C;
      end
      pmfn_pkg::ST_SIN_U2C: begin
        cmd.mul_sel  = pmfn_pkg::MUL_U2C;
        cmd.mul_en   = 1'b1;
        cmd.u2_latch = 1'b1;
        state_next   = pmfn_pkg::ST_SIN_R1;
      end
      pmfn_pkg::ST_SIN_R1: begin
        cmd.mul_sel = pmfn_pkg::MUL_R1;
        cmd.mul_en  = 1'b1;
        state_next  = pmfn_pkg::ST_SIN_R2;
      end
      pmfn_pkg::ST_SIN_R2: begin
        cmd.mul_sel = pmfn_pkg::MUL_R2;
        cmd.mul_en  = 1'b1;
        state_next  = pmfn_pkg::ST_FINISH;
      end
      pmfn_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = pmfn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pmfn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pmfn_datapath.sv =====
`default_nettype none

module pmfn_datapath #(
  parameter int TAPS       = pmfn_pkg::TAPS_DEFAULT,
  parameter int PHASE_BITS = pmfn_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [15:0]               sample_in,
  input  logic                             cfg_we,
  input  logic [pmfn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmfn_pkg::CFG_W-1:0]       cfg_data,
  input  pmfn_pkg::ctl_cmd_t               cmd,
  output pmfn_pkg::ctl_stat_t              stat,
  pmfn_result_if.source                    result_ch
);

  localparam int AW    = $clog2(TAPS);
  localparam int SHIFT = 15 - PHASE_BITS;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
  localparam logic signed [17:0] PMASK = 18'((1 << PHASE_BITS) - 1);

  logic [pmfn_pkg::CFG_W-1:0] free_inc;
  logic [pmfn_pkg::CFG_W-1:0] loop_gain;

  logic signed [15:0] sample_q;
  logic signed [15:0] last_vco;
  logic signed [15:0] acc;
  logic [AW-1:0]      hist_idx;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      tap_cnt;

  logic signed [15:0] hist_mem [TAPS];
  logic [TAPS-1:0]    hist_vld;
  logic signed [15:0] rdata_q;
  logic               rvld_q;
  logic signed [15:0] coef_q;
  logic               v1, v2;

  logic signed [35:0] prod_q;
  logic signed [17:0] mul_a, mul_b;
  logic               mul_fire;

  logic [PHASE_BITS-1:0] phase_off;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [15:0]           u_q;
  logic [15:0]           u2_q;
  logic [1:0]            quad_q;

  logic               out_valid;
  logic signed [15:0] vco_q;
  logic signed [15:0] err_q;

  logic signed [15:0] det;
  logic signed [15:0] gain_term;
  logic signed [17:0] ph, ph1, ph2;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [14:0]        phase15;
  logic [13:0]        tfold;
  logic [16:0]        r1, r2;
  logic [16:0]        y_raw;
  logic signed [15:0] y_sat;
  logic signed [15:0] vco_new;

  assign det       = pmfn_pkg::qsat(prod_q);
  assign gain_term = pmfn_pkg::qsat(prod_q);

  // shared multiplier operand select
  always_comb begin
    r1 = pmfn_pkg::SIN_K2 - prod_q[31:15];
    r2 = pmfn_pkg::SIN_K1 - prod_q[31:15];
    unique case (cmd.mul_sel)
      pmfn_pkg::MUL_DET: begin
        mul_a = {{2{sample_q[15]}}, sample_q};
        mul_b = {{2{last_vco[15]}}, last_vco};
      end
      pmfn_pkg::MUL_TAP: begin
        mul_a = rvld_q ? {{2{rdata_q[15]}}, rdata_q} : 18'sd0;
        mul_b = {{2{coef_q[15]}}, coef_q};
      end
      pmfn_pkg::MUL_GAIN: begin
        mul_a = {{2{acc[15]}}, acc};
        mul_b = {3'b000, loop_gain};
      end
      pmfn_pkg::MUL_UU: begin
        mul_a = {2'b00, u_q};
        mul_b = {2'b00, u_q};
      end
      pmfn_pkg::MUL_U2C: begin
        mul_a = {2'b00, prod_q[30:15]};
        mul_b = {2'b00, pmfn_pkg::SIN_K3};
      end
      pmfn_pkg::MUL_R1: begin
        mul_a = {2'b00, u2_q};
        mul_b = {1'b0, r1};
      end
      pmfn_pkg::MUL_R2: begin
        mul_a = {2'b00, u_q};
        mul_b = {1'b0, r2};
      end
      default: begin
        mul_a = 18'sd0;
        mul_b = 18'sd0;
      end
    endcase
    mul_fire = (cmd.mul_sel == pmfn_pkg::MUL_TAP) ? v1 : cmd.mul_en;
  end

  // phase offset update with single wrap, then mask
  always_comb begin
    ph  = $signed({{2{gain_term[15]}}, gain_term}) + $signed(18'(phase_off));
    ph1 = (ph > PMASK) ? ph - PMASK : ph;
    ph2 = (ph1 < 18'sd0) ? ph1 + PMASK : ph1;
  end

  // quarter-wave fold of the sine phase
  always_comb begin
    phase_sum = phase_acc + phase_off;
    phase15   = 15'(phase_sum) << SHIFT;
    tfold     = phase15[13] ? pmfn_pkg::SIN_QUARTER - {1'b0, phase15[12:0]}
                            : {1'b0, phase15[12:0]};
  end

  always_comb begin
    y_raw   = prod_q[31:15];
    y_sat   = (y_raw > 17'd32767) ? 16'sh7fff : $signed(y_raw[15:0]);
    vco_new = quad_q[1] ? -y_sat : y_sat;
  end

  // control state and state that the loop carries across items
  always_ff @(posedge clk) begin
    if (rst) begin
      free_inc  <= pmfn_pkg::FREE_RUN_RESET;
      loop_gain <= pmfn_pkg::LOOP_GAIN_RESET;
      hist_idx  <= '0;
      hist_vld  <= '0;
      last_vco  <= 16'sd0;
      phase_off <= '0;
      phase_acc <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pmfn_pkg::REG_FREE_RUN_INCREMENT) begin
          free_inc <= cfg_data;
        end else if (cfg_index == pmfn_pkg::REG_LOOP_GAIN) begin
          loop_gain <= cfg_data;
        end
      end
      if (cmd.det_write) begin
        hist_vld[hist_idx] <= 1'b1;
      end
      if (cmd.hist_step) begin
        hist_idx <= (hist_idx == '0) ? LAST : hist_idx - 1'b1;
      end
      if (cmd.phase_upd) begin
        phase_off <= ph2[PHASE_BITS-1:0];
        phase_acc <= phase_acc + free_inc[PHASE_BITS-1:0];
      end
      v1 <= cmd.tap_issue;
      v2 <= v1;
      if (cmd.finish) begin
        last_vco  <= vco_new;
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // delay line memory and tap read stage
  always_ff @(posedge clk) begin
    if (cmd.det_write) begin
      hist_mem[hist_idx] <= det;
    end
    if (cmd.tap_issue) begin
      rdata_q <= hist_mem[rd_addr];
      rvld_q  <= hist_vld[rd_addr];
      coef_q  <= pmfn_pkg::coef_at(8'(tap_cnt));
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample_in;
    end
    if (mul_fire) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd.det_write) begin
      rd_addr <= hist_idx;
      tap_cnt <= '0;
      acc     <= 16'sd0;
    end else begin
      if (cmd.tap_issue) begin
        rd_addr <= (rd_addr == LAST) ? '0 : rd_addr + 1'b1;
        tap_cnt <= tap_cnt + 1'b1;
      end
      if (v2) begin
        acc <= pmfn_pkg::sat_add(acc, pmfn_pkg::qsat(prod_q));
      end
    end
    if (cmd.sin_prep) begin
      u_q    <= {tfold, 2'b00};
      quad_q <= phase15[14:13];
    end
    if (cmd.u2_latch) begin
      u2_q <= prod_q[30:15];
    end
    if (cmd.finish) begin
      vco_q <= vco_new;
      err_q <= acc;
    end
  end

  assign stat.last_issue = (tap_cnt == LAST);
  assign stat.pipe_busy  = v1 | v2;
  assign stat.out_busy   = out_valid & ~result_ch.ready;

  assign result_ch.valid        = out_valid;
  assign result_ch.vco_sample   = vco_q;
  assign result_ch.error_sample = err_q;

endmodule

`default_nettype wire

// ===== src/pll_mixer_fir_nco_core.sv =====
// The single shared multiplier first forms the detector product, then walks the delay
// line one tap per cycle, then runs the gain and four sine products. A new sample is
// taken only once the previous one is through and the control is back in idle.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst, synchronous): delay line reads as zero, loop state cleared,
// increment 341 and loop gain 137; no clearing pass.
`default_nettype none

module pll_mixer_fir_nco_core #(
  parameter int TAPS       = pmfn_pkg::TAPS_DEFAULT,
  parameter int PHASE_BITS = pmfn_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  pmfn_sample_if.sink                    sample_ch,
  pmfn_result_if.source                  result_ch,
  input  logic                           cfg_we,
  input  logic [pmfn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmfn_pkg::CFG_W-1:0]     cfg_data
);

  pmfn_pkg::ctl_cmd_t  cmd;
  pmfn_pkg::ctl_stat_t stat;

  assign sample_ch.ready = cmd.in_ready;

  pmfn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pmfn_datapath #(
    .TAPS       (TAPS),
    .PHASE_BITS (PHASE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_ch.sample_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

// ===== src/pmfn_checker.sv =====
`default_nettype none

module pmfn_checker (
  input logic               clk,
  input logic               rst,
  input logic               s_valid,
  input logic               s_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic signed [15:0] r_vco,
  input logic signed [15:0] r_err
);

  logic       s_acc, r_acc;
  logic [1:0] outstanding;

  assign s_acc = s_valid & s_ready;
  assign r_acc = r_valid & r_ready;

  // words taken in but not yet handed out
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else begin
      outstanding <= outstanding + {1'b0, s_acc} - {1'b0, r_acc};
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> $stable(r_vco) && $stable(r_err))
    else $error("result word changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    r_acc |-> outstanding != 2'd0)
    else $error("result word with no sample behind it");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two words in flight");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_ready)
    else $error("sample taken while the previous one is in work");

endmodule

bind pll_mixer_fir_nco_core pmfn_checker u_pmfn_checker (
  .clk     (clk),
  .rst     (rst),
  .s_valid (sample_ch.valid),
  .s_ready (sample_ch.ready),
  .r_valid (result_ch.valid),
  .r_ready (result_ch.ready),
  .r_vco   (result_ch.vco_sample),
  .r_err   (result_ch.error_sample)
);

`default_nettype wire
